[src/ecsf_pkg.sv]
// Shared types and constants for the edge-clocked sample FIFO.
// No dependencies; used by the interfaces, ecsf_ctrl and the top level.
`default_nettype none

package ecsf_pkg;

  localparam int WORD_W     = 64;
  localparam int OCC_W      = 11;
  localparam int UNDERRUN_W = 31;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0]  REG_DEPTH_IN_USE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_READ_CLOCK_MODE = 1'd1;
  localparam logic [CFG_DATA_W-1:0] DEPTH_IN_USE_RST    = 11'd1024;

  localparam logic [UNDERRUN_W-1:0] UNDERRUN_MAX = {UNDERRUN_W{1'b1}};

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    MODE_FREE = 2'd0,
    MODE_FALL = 2'd1,
    MODE_RISE = 2'd2,
    MODE_ANY  = 2'd3
  } clk_mode_t;

  // per-item status produced by the control logic, held in the result stage
  typedef struct packed {
    logic                  accepted;
    logic                  sample_valid;
    logic [OCC_W-1:0]      occupancy;
    logic                  is_empty;
    logic [UNDERRUN_W-1:0] underrun_count;
  } status_t;

endpackage

`default_nettype wire

[src/ecsf_if.sv]
// Valid/ready channel interfaces for the input items and the result items.
// Depends on ecsf_pkg for field widths.
`default_nettype none

interface ecsf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [ecsf_pkg::WORD_W-1:0]   sample_word;
  logic                          chunk_last;
  logic                          read_enable;
  logic                          strobe_req;

  modport source (output valid, op, sample_word, chunk_last, read_enable, strobe_req,
                  input ready);
  modport sink   (input valid, op, sample_word, chunk_last, read_enable, strobe_req,
                  output ready);
endinterface

interface ecsf_out_if;
  logic                              valid;
  logic                              ready;
  logic                              accepted;
  logic                              sample_valid;
  logic [ecsf_pkg::WORD_W-1:0]       sample_out;
  logic [ecsf_pkg::OCC_W-1:0]        occupancy;
  logic                              is_empty;
  logic [ecsf_pkg::UNDERRUN_W-1:0]   underrun_count;

  modport source (output valid, accepted, sample_valid, sample_out, occupancy, is_empty,
                  underrun_count, input ready);
  modport sink   (input valid, accepted, sample_valid, sample_out, occupancy, is_empty,
                  underrun_count, output ready);
endinterface

`default_nettype wire

[src/ecsf_store.sv]
// Ring sample store: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
`default_nettype none

module ecsf_store #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read, so a stalled result keeps its sample
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[src/ecsf_ctrl.sv]
// FIFO control: config registers, ring pointers, fill count, edge history,
// underrun counter and per-item status. Depends on ecsf_pkg.
`default_nettype none

module ecsf_ctrl #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                item_fire,
  input  wire logic                                op,
  input  wire logic                                read_enable,
  input  wire logic                                strobe_req,
  input  wire logic                                cfg_we,
  input  wire logic [ecsf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ecsf_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                     wr_en,
  output logic      [AW-1:0]                       wr_addr,
  output logic                                     rd_en,
  output logic      [AW-1:0]                       rd_addr,
  output ecsf_pkg::status_t                        status
);

  localparam int OW = ecsf_pkg::OCC_W;
  localparam int UW = ecsf_pkg::UNDERRUN_W;
  localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  logic [ecsf_pkg::CFG_DATA_W-1:0] depth_r;
  ecsf_pkg::clk_mode_t             mode_r;
  logic [AW-1:0]                   wptr_r, wptr_nxt;
  logic [AW-1:0]                   rptr_r, rptr_nxt;
  logic [CW-1:0]                   fill_r, fill_nxt;
  logic [1:0]                      hist_r, hist_nxt;
  logic [UW-1:0]                   underrun_r, underrun_nxt;
  logic                            push_ok;
  logic                            fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= ecsf_pkg::DEPTH_IN_USE_RST;
      mode_r  <= ecsf_pkg::MODE_FREE;
    end else if (cfg_we) begin
      case (cfg_index)
        ecsf_pkg::REG_DEPTH_IN_USE:    depth_r <= cfg_data;
        ecsf_pkg::REG_READ_CLOCK_MODE: mode_r  <= ecsf_pkg::clk_mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r     <= '0;
      rptr_r     <= '0;
      fill_r     <= '0;
      hist_r     <= '0;
      underrun_r <= '0;
    end else begin
      wptr_r     <= wptr_nxt;
      rptr_r     <= rptr_nxt;
      fill_r     <= fill_nxt;
      hist_r     <= hist_nxt;
      underrun_r <= underrun_nxt;
    end
  end

  // limit is min(depth in use, DEPTH)
  assign push_ok = (fill_r < DEPTH_CNT) && (32'(fill_r) < 32'(depth_r));

  always_comb begin
    wptr_nxt     = wptr_r;
    rptr_nxt     = rptr_r;
    fill_nxt     = fill_r;
    hist_nxt     = hist_r;
    underrun_nxt = underrun_r;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    fire         = 1'b0;
    status.accepted     = 1'b0;
    status.sample_valid = 1'b0;

    if (item_fire) begin
      if (op == ecsf_pkg::OP_PUSH) begin
        if (push_ok) begin
          wr_en           = 1'b1;
          wptr_nxt        = (wptr_r == LAST_IDX) ? '0 : wptr_r + 1'b1;
          fill_nxt        = fill_r + 1'b1;
          status.accepted = 1'b1;
        end
      end else if (read_enable) begin
        hist_nxt = {hist_r[0], strobe_req};
        case (mode_r)
          ecsf_pkg::MODE_FREE: fire = 1'b1;
          ecsf_pkg::MODE_FALL: fire = (hist_nxt == 2'b10);
          ecsf_pkg::MODE_RISE: fire = (hist_nxt == 2'b01);
          ecsf_pkg::MODE_ANY:  fire = hist_nxt[1] ^ hist_nxt[0];
          default:             fire = 1'b0;
        endcase
        if (fire) begin
          if (fill_r == '0) begin
            if (underrun_r != ecsf_pkg::UNDERRUN_MAX) begin
              underrun_nxt = underrun_r + 1'b1;
            end
          end else begin
            rd_en               = 1'b1;
            rptr_nxt            = (rptr_r == LAST_IDX) ? '0 : rptr_r + 1'b1;
            fill_nxt            = fill_r - 1'b1;
            status.sample_valid = 1'b1;
          end
        end
      end
    end

    status.occupancy      = OW'(fill_r);
    status.is_empty       = (fill_r == '0);
    status.underrun_count = underrun_nxt;
  end

  assign wr_addr = wptr_r;
  assign rd_addr = rptr_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_CNT)
    else $error("fill count above ring depth");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (fill_r == $past(fill_r)) || (fill_r == $past(fill_r) + 1'b1) ||
             (fill_r == $past(fill_r) - 1'b1))
    else $error("fill count moved by more than one");

  a_underrun_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (underrun_r == $past(underrun_r)) ||
             (underrun_r == $past(underrun_r) + 1'b1))
    else $error("underrun counter not monotonic");

endmodule

`default_nettype wire

[src/edge_clocked_sample_fifo.sv]
// Top level of the edge-clocked sample FIFO: control, ring store and result stage.
// Depends on ecsf_pkg, ecsf_if, ecsf_ctrl and ecsf_store.
// The result is registered and valid in the cycle after the item is accepted.
// Throughput: one item per cycle while the output is ready; the result register frees as it is taken.
// Reset (rst_n, synchronous): pointers, fill count, edge history and underrun
// counter clear, depth in use returns to 1024 and clock mode to free run.
`default_nettype none

module edge_clocked_sample_fifo #(
  parameter int DEPTH       = 1024,
  parameter int SAMPLE_BITS = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  ecsf_in_if.sink                               in_ch,
  ecsf_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [ecsf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ecsf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = ecsf_pkg::WORD_W;

  logic                   item_fire;
  logic                   wr_en;
  logic                   rd_en;
  logic [AW-1:0]          wr_addr;
  logic [AW-1:0]          rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data_r;
  ecsf_pkg::status_t      status;
  ecsf_pkg::status_t      res_r;
  logic                   out_valid_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign item_fire   = in_ch.valid && in_ch.ready;

  ecsf_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_fire   (item_fire),
    .op          (in_ch.op),
    .read_enable (in_ch.read_enable),
    .strobe_req  (in_ch.strobe_req),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .status      (status)
  );

  ecsf_store #(
    .DEPTH (DEPTH),
    .WIDTH (SAMPLE_BITS),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (in_ch.sample_word[SAMPLE_BITS-1:0]),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= item_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      res_r <= status;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.accepted       = res_r.accepted;
  assign out_ch.sample_valid   = res_r.sample_valid;
  assign out_ch.sample_out     = res_r.sample_valid ? WW'(rd_data_r) : '0;
  assign out_ch.occupancy      = res_r.occupancy;
  assign out_ch.is_empty       = res_r.is_empty;
  assign out_ch.underrun_count = res_r.underrun_count;

  a_push_or_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.accepted && out_ch.sample_valid))
    else $error("item both stored and popped");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.sample_valid |-> !out_ch.is_empty)
    else $error("sample popped from empty FIFO");

  a_push_ready_path: assert property (@(posedge clk) disable iff (!rst_n)
    item_fire |=> out_ch.valid)
    else $error("accepted item produced no result");

endmodule

`default_nettype wire
